// ===== src/ssr_pkg.sv =====
package ssr_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int KEY_W     = 64;
	localparam int PAY_W     = 64;
	localparam int POS_W     = 5;
	localparam int ACT_W     = 3;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH   = 3'd0,
		ACT_POP    = 3'd1,
		ACT_FIND   = 3'd2,
		ACT_READ   = 3'd3,
		ACT_REMOVE = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		MOVE_HOLD = 2'd0,
		MOVE_PREV = 2'd1,
		MOVE_NEXT = 2'd2
	} cell_move_t;

	typedef struct packed {
		cell_move_t       move;
		logic [KEY_W-1:0] find_key;
	} cell_ctrl_t;

endpackage

// ===== src/ssr_cell.sv =====
module ssr_cell (
	input  logic                     clk,
	input  ssr_pkg::cell_ctrl_t      ctrl,
	input  logic [ssr_pkg::KEY_W-1:0] prev_key,
	input  logic [ssr_pkg::PAY_W-1:0] prev_payload,
	input  logic [ssr_pkg::KEY_W-1:0] next_key,
	input  logic [ssr_pkg::PAY_W-1:0] next_payload,
	output logic [ssr_pkg::KEY_W-1:0] key,
	output logic [ssr_pkg::PAY_W-1:0] payload,
	output logic                     hit
);
	import ssr_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] payload_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.move)
			MOVE_PREV: begin
				key_q     <= prev_key;
				payload_q <= prev_payload;
			end
			MOVE_NEXT: begin
				key_q     <= next_key;
				payload_q <= next_payload;
			end
			default: begin
				key_q     <= key_q;
				payload_q <= payload_q;
			end
		endcase
	end

	assign key     = key_q;
	assign payload = payload_q;
	assign hit     = (key_q == ctrl.find_key);

endmodule

// ===== src/searchable_stack_with_remove_at_unit.sv =====
// Channel  Handshake            Payload
// req      req_valid/req_stall  action, key_in, payload_in, slot_from_top
// rsp      rsp_valid/rsp_stall  ok, found_slot, key_out, payload_out,
//                               fill_count, is_empty, is_full
//
// One item per cycle is sustained while rsp_stall is low; each result passes through
// stage one, stage two and the result register. The row of cells shifts or holds as the
// item leaves stage one, and the nearest-match search is encoded in the following stage.
// Reset clears the fill count and empties the pipeline; the stored entries are not cleared.
// rsp_stall holds the result register; items are still taken while an earlier stage is free.
module searchable_stack_with_remove_at_unit #(
	parameter int DEPTH = ssr_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [ssr_pkg::ACT_W-1:0] action,
	input  logic [ssr_pkg::KEY_W-1:0] key_in,
	input  logic [ssr_pkg::PAY_W-1:0] payload_in,
	input  logic [ssr_pkg::POS_W-1:0] slot_from_top,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic                      ok,
	output logic [ssr_pkg::POS_W-1:0] found_slot,
	output logic [ssr_pkg::KEY_W-1:0] key_out,
	output logic [ssr_pkg::PAY_W-1:0] payload_out,
	output logic [ssr_pkg::POS_W-1:0] fill_count,
	output logic                      is_empty,
	output logic                      is_full
);
	import ssr_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Flow control: each stage loads when it is empty or the one after it moves on.
	logic adv_out, adv_s2, adv_s1, s1_fire;

	logic             valid_s1;
	action_t          action_s1;
	logic [KEY_W-1:0] key_s1;
	logic [PAY_W-1:0] payload_s1;
	logic [POS_W-1:0] pos_s1;

	logic             valid_s2;
	logic             find_s2;
	logic [DEPTH-1:0] hit_s2;
	logic             ok_s2;
	logic [KEY_W-1:0] key_s2;
	logic [PAY_W-1:0] payload_s2;
	logic [CNT_W-1:0] cnt_s2;

	logic             rsp_valid_q;
	logic             ok_q;
	logic [POS_W-1:0] found_q;
	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] payload_q;
	logic [POS_W-1:0] fill_q;
	logic             empty_q;
	logic             full_q;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_next;

	cell_ctrl_t       ctrl   [DEPTH];
	logic [KEY_W-1:0] cell_key [DEPTH];
	logic [PAY_W-1:0] cell_pay [DEPTH];
	logic [DEPTH-1:0] cell_hit;

	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic [IDX_W-1:0] rd_idx;
	logic             stack_full, stack_empty, pos_ok;
	logic             push_go, pop_go, rem_go, read_go;
	logic             ok_s1;
	logic [KEY_W-1:0] rd_key;
	logic [PAY_W-1:0] rd_pay;
	logic [DEPTH-1:0] hit_s1;

	logic             any_hit;
	logic [CMP_W-1:0] found_full;
	logic             ok_fin;
	logic [POS_W-1:0] found_fin;
	logic [CMP_W-1:0] cnt_s2_ext;

	assign adv_out   = !rsp_valid_q || !rsp_stall;
	assign adv_s2    = !valid_s2 || adv_out;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign s1_fire   = valid_s1 && adv_s2;
	assign req_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req_valid) begin
			action_s1  <= action_t'(action);
			key_s1     <= key_in;
			payload_s1 <= payload_in;
			pos_s1     <= slot_from_top;
		end
	end

	// Stage one: decide the operation against the current fill count.
	assign pos_ext     = CMP_W'(pos_s1);
	assign cnt_ext     = CMP_W'(cnt_q);
	assign stack_full  = (cnt_q == CNT_W'(DEPTH));
	assign stack_empty = (cnt_q == '0);
	assign pos_ok      = (pos_s1 != '0) && (pos_ext <= cnt_ext);
	assign push_go     = (action_s1 == ACT_PUSH) && !stack_full;
	assign pop_go      = (action_s1 == ACT_POP) && !stack_empty;
	assign rem_go      = (action_s1 == ACT_REMOVE) && pos_ok;
	assign read_go     = (action_s1 == ACT_READ) && pos_ok;
	assign rd_idx      = IDX_W'(pos_ext - CMP_W'(1));

	always_comb begin
		ok_s1 = push_go || pop_go || rem_go || read_go;
		if (push_go) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (pop_go || rem_go) begin
			cnt_next = cnt_q - CNT_W'(1);
		end else begin
			cnt_next = cnt_q;
		end
		rd_key = read_go ? cell_key[rd_idx] : '0;
		rd_pay = read_go ? cell_pay[rd_idx] : '0;
	end

	// Cell i holds the entry at position i + 1; cells at or below a removed position
	// take from their lower neighbour, which closes the gap.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ctrl[i].find_key = key_s1;
			ctrl[i].move     = MOVE_HOLD;
			if (s1_fire) begin
				if (push_go) begin
					ctrl[i].move = MOVE_PREV;
				end else if (pop_go) begin
					ctrl[i].move = MOVE_NEXT;
				end else if (rem_go && (CMP_W'(i + 1) >= pos_ext)) begin
					ctrl[i].move = MOVE_NEXT;
				end
			end
			hit_s1[i] = cell_hit[i] && (CMP_W'(i) < cnt_ext) && (action_s1 == ACT_FIND);
		end
	end

	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		logic [KEY_W-1:0] p_key, n_key;
		logic [PAY_W-1:0] p_pay, n_pay;
		if (gi == 0) begin : g_top
			assign p_key = key_s1;
			assign p_pay = payload_s1;
		end else begin : g_mid
			assign p_key = cell_key[gi-1];
			assign p_pay = cell_pay[gi-1];
		end
		if (gi == DEPTH - 1) begin : g_bot
			assign n_key = cell_key[gi];
			assign n_pay = cell_pay[gi];
		end else begin : g_inner
			assign n_key = cell_key[gi+1];
			assign n_pay = cell_pay[gi+1];
		end
		ssr_cell u_cell (
			.clk          (clk),
			.ctrl         (ctrl[gi]),
			.prev_key     (p_key),
			.prev_payload (p_pay),
			.next_key     (n_key),
			.next_payload (n_pay),
			.key          (cell_key[gi]),
			.payload      (cell_pay[gi]),
			.hit          (cell_hit[gi])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_fire) begin
				cnt_q <= cnt_next;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			find_s2    <= (action_s1 == ACT_FIND);
			hit_s2     <= hit_s1;
			ok_s2      <= ok_s1;
			key_s2     <= rd_key;
			payload_s2 <= rd_pay;
			cnt_s2     <= cnt_next;
		end
	end

	// Stage two: the hit cell with the lowest index is the nearest match to the top.
	always_comb begin
		any_hit    = 1'b0;
		found_full = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hit_s2[i]) begin
				any_hit    = 1'b1;
				found_full = CMP_W'(i + 1);
			end
		end
		ok_fin     = find_s2 ? any_hit : ok_s2;
		found_fin  = (find_s2 && any_hit) ? found_full[POS_W-1:0] : '0;
		cnt_s2_ext = CMP_W'(cnt_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_out) begin
			rsp_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s2) begin
			ok_q      <= ok_fin;
			found_q   <= found_fin;
			key_q     <= key_s2;
			payload_q <= payload_s2;
			fill_q    <= cnt_s2_ext[POS_W-1:0];
			empty_q   <= (cnt_s2 == '0);
			full_q    <= (cnt_s2 == CNT_W'(DEPTH));
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign ok          = ok_q;
	assign found_slot  = found_q;
	assign key_out     = key_q;
	assign payload_out = payload_q;
	assign fill_count  = fill_q;
	assign is_empty    = empty_q;
	assign is_full     = full_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_count_moves_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> $past(s1_fire))
		else $error("fill count changed without an item leaving stage one");

	a_fail_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !ok |-> (key_out == '0) && (payload_out == '0))
		else $error("failed item carries entry data");

	a_found_implies_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (found_slot != '0) |-> ok)
		else $error("match position given without ok");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(is_empty && is_full))
		else $error("empty and full both set");

endmodule
